// ===== sv/bhfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bhfp_pkg
// Shared types and constants of the bitstream header field parser.
// ----------------------------------------------------------------------------
package bhfp_pkg;

  // Parse phases, one-hot
  typedef enum logic [10:0] {
    PH_HLEN_HI  = 11'b000_0000_0001,
    PH_HLEN_LO  = 11'b000_0000_0010,
    PH_SKIP     = 11'b000_0000_0100,
    PH_TAG      = 11'b000_0000_1000,
    PH_LEN16_HI = 11'b000_0001_0000,
    PH_LEN16_LO = 11'b000_0010_0000,
    PH_LEN32_0  = 11'b000_0100_0000,
    PH_LEN32_1  = 11'b000_1000_0000,
    PH_LEN32_2  = 11'b001_0000_0000,
    PH_LEN32_3  = 11'b010_0000_0000,
    PH_IDLE     = 11'b100_0000_0000
  } phase_t;

  // Event kinds reported on the result channel
  localparam logic [2:0] EV_NAME    = 3'd0;
  localparam logic [2:0] EV_PART    = 3'd1;
  localparam logic [2:0] EV_DATE    = 3'd2;
  localparam logic [2:0] EV_TIME    = 3'd3;
  localparam logic [2:0] EV_DATA    = 3'd4;
  localparam logic [2:0] EV_UNKNOWN = 3'd5;
  localparam logic [2:0] EV_TRUNC   = 3'd6;

  // Tag characters
  localparam logic [7:0] TAG_A = 8'h61;
  localparam logic [7:0] TAG_D = 8'h64;
  localparam logic [7:0] TAG_E = 8'h65;

  // Extra bytes skipped after the leading field
  localparam logic [31:0] HDR_EXTRA_SKIP = 32'd2;

endpackage

// ===== sv/bhfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// bhfp_byte_if
// Valid/ready channel carrying one bitstream byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface bhfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/bhfp_event_if.sv =====
// ----------------------------------------------------------------------------
// bhfp_event_if
// Valid/ready channel carrying one parser event: kind, offset and length.
// ----------------------------------------------------------------------------
interface bhfp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] field_offset;
  logic [31:0] field_length;

  modport source (output valid, output event_kind, output field_offset,
                  output field_length, input ready);
  modport sink   (input valid, input event_kind, input field_offset,
                  input field_length, output ready);
endinterface

// ===== sv/bitstream_header_field_parser.sv =====
// ----------------------------------------------------------------------------
// bitstream_header_field_parser
// Byte-serial parser of a tagged bitstream file header; reports the name,
// part, date, time and configuration data fields with offset and length.
// ----------------------------------------------------------------------------
//  channel  | role   | payload
//  ---------+--------+------------------------------------------------
//  bytes    | sink   | data_byte[7:0], last_byte
//  events   | source | event_kind[2:0], field_offset[31:0], field_length[31:0]
//
// One byte per cycle sustained while results are taken; a byte passes the
// input register and the parse logic, and its event is registered in the
// result register. The single header state machine sets the rate.
// A held result stalls the parser only while it is not taken; during the
// stall the input register holds one byte and then drops its ready.
// Synchronous reset returns the parser to the first length byte.
// ----------------------------------------------------------------------------
module bitstream_header_field_parser
  import bhfp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  bhfp_byte_if.sink    bytes,
  bhfp_event_if.source events
);

  bhfp_byte_if held ();

  // Register incoming byte requests
  bhfp_in_reg u_in_reg (
    .clk (clk),
    .rst (rst),
    .up  (bytes),
    .dn  (held.source)
  );

  // Parse and register events
  bhfp_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .item (held.sink),
    .evt  (events)
  );

endmodule

// ===== sv/bhfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// bhfp_in_reg
// Input register: captures one byte request and holds it until the parser
// takes it; refills in the same cycle the held byte leaves.
// ----------------------------------------------------------------------------
module bhfp_in_reg (
  input  logic        clk,
  input  logic        rst,
  bhfp_byte_if.sink   up,
  bhfp_byte_if.source dn
);

  logic       valid;
  logic [7:0] data_byte;
  logic       last_byte;

  // Accept when empty or when the held byte is taken this cycle
  assign up.ready     = !valid || dn.ready;
  assign dn.valid     = valid;
  assign dn.data_byte = data_byte;
  assign dn.last_byte = last_byte;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up.ready) begin
      valid <= up.valid;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      data_byte <= up.data_byte;
      last_byte <= up.last_byte;
    end
  end

endmodule

// ===== sv/bhfp_parser.sv =====
// ----------------------------------------------------------------------------
// bhfp_parser
// Header state machine and result register: updates the parse state for one
// byte per cycle while the result slot is free and registers the event that byte produces.
// ----------------------------------------------------------------------------
module bhfp_parser
  import bhfp_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  bhfp_byte_if.sink     item,
  bhfp_event_if.source  evt
);

  // State registers
  phase_t                 phase;
  logic [OFFSET_BITS-1:0] pos;
  logic [31:0]            acc;
  logic [31:0]            skip;
  logic [2:0]             tag;

  phase_t                 phase_next;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [31:0]            acc_next;
  logic [31:0]            skip_next;
  logic [2:0]             tag_next;

  // Result register
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [31:0] out_offset;
  logic [31:0] out_length;

  // Event of the current byte
  logic        ev;
  logic [2:0]  ev_kind;
  logic [31:0] ev_offset;
  logic [31:0] ev_length;

  logic        take;
  logic [63:0] pos_wide;
  logic [63:0] pos_inc_wide;
  logic [31:0] skip_dec;
  logic [31:0] len16;
  logic [31:0] len32;

  // Advance when a byte is held and the result slot is free
  assign take       = item.valid && (!out_valid || evt.ready);
  assign item.ready = take;

  assign pos_next     = pos + 1'b1;
  assign pos_wide     = 64'(pos);
  assign pos_inc_wide = 64'(pos_next);
  assign skip_dec     = (skip == '0) ? '0 : skip - 32'd1;
  assign len16        = {acc[31:8], item.data_byte};
  assign len32        = {acc[23:0], item.data_byte};

  // Next state and event for the held byte
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    skip_next  = skip;
    tag_next   = tag;
    ev         = 1'b0;
    ev_kind    = EV_TRUNC;
    ev_offset  = pos_wide[31:0];
    ev_length  = '0;

    unique case (phase)
      PH_HLEN_HI: begin
        acc_next   = {16'd0, item.data_byte, 8'd0};
        phase_next = PH_HLEN_LO;
      end
      PH_HLEN_LO: begin
        skip_next  = len16 + HDR_EXTRA_SKIP;
        phase_next = PH_SKIP;
      end
      PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = PH_TAG;
        end
      end
      PH_TAG: begin
        priority if (item.data_byte == TAG_E) begin
          acc_next   = '0;
          phase_next = PH_LEN32_0;
        end else if (item.data_byte >= TAG_A && item.data_byte <= TAG_D) begin
          tag_next   = 3'(item.data_byte - TAG_A);
          acc_next   = '0;
          phase_next = PH_LEN16_HI;
        end else begin
          ev         = 1'b1;
          ev_kind    = EV_UNKNOWN;
          phase_next = PH_IDLE;
        end
      end
      PH_LEN16_HI: begin
        acc_next   = {16'd0, item.data_byte, 8'd0};
        phase_next = PH_LEN16_LO;
      end
      PH_LEN16_LO: begin
        acc_next   = len16;
        skip_next  = len16;
        ev         = 1'b1;
        ev_kind    = tag;
        ev_offset  = pos_inc_wide[31:0];
        ev_length  = len16;
        phase_next = (len16 == '0) ? PH_TAG : PH_SKIP;
      end
      PH_LEN32_0: begin
        acc_next   = len32;
        phase_next = PH_LEN32_1;
      end
      PH_LEN32_1: begin
        acc_next   = len32;
        phase_next = PH_LEN32_2;
      end
      PH_LEN32_2: begin
        acc_next   = len32;
        phase_next = PH_LEN32_3;
      end
      PH_LEN32_3: begin
        acc_next   = len32;
        ev         = 1'b1;
        ev_kind    = EV_DATA;
        ev_offset  = pos_inc_wide[31:0];
        ev_length  = len32;
        phase_next = PH_IDLE;
      end
      PH_IDLE: begin
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // Last byte: flag truncation if nothing ended the header, then restart
    if (item.last_byte) begin
      if (!ev && phase_next != PH_IDLE) begin
        ev        = 1'b1;
        ev_kind   = EV_TRUNC;
        ev_offset = pos_wide[31:0];
        ev_length = '0;
      end
      phase_next = PH_HLEN_HI;
      acc_next   = '0;
      skip_next  = '0;
      tag_next   = '0;
    end
  end

  // Advance parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HLEN_HI;
      pos   <= '0;
      acc   <= '0;
      skip  <= '0;
      tag   <= '0;
    end else if (take) begin
      phase <= phase_next;
      pos   <= item.last_byte ? '0 : pos_next;
      acc   <= acc_next;
      skip  <= skip_next;
      tag   <= tag_next;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && ev) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev) begin
      out_kind   <= ev_kind;
      out_offset <= ev_offset;
      out_length <= ev_length;
    end
  end

  assign evt.valid        = out_valid;
  assign evt.event_kind   = out_kind;
  assign evt.field_offset = out_offset;
  assign evt.field_length = out_length;

`ifndef ASSERT_OFF
  // A last byte always returns the parser to its start
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    (take && item.last_byte) |=> (phase == PH_HLEN_HI && pos == '0))
    else $error("parser did not restart after last byte");

  // The ignore phase is left only through a last byte
  a_idle_sticky: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_IDLE && !item.last_byte) |=> phase == PH_IDLE)
    else $error("parser left ignore phase without last byte");

  // A skip phase always has bytes left to skip
  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (skip != '0))
    else $error("skip phase with zero count");

  // Only defined event kinds reach the result register
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind <= EV_TRUNC))
    else $error("undefined event kind");
`endif

endmodule

// ===== tb/bitstream_header_field_parser_tb.sv =====
// ----------------------------------------------------------------------------
// bitstream_header_field_parser_tb
// Self-checking bench for the bitstream header field parser. Byte requests go
// in under random bursts and gaps, event requests come out under a changing
// stall pattern, and every event is compared field by field against a
// cycle-free model of the header parser kept inside the bench.
// ----------------------------------------------------------------------------
module bitstream_header_field_parser_tb;
  import bhfp_pkg::*;

  localparam int          OFFSET_BITS  = 32;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [7:0]  TAG_B        = TAG_A + 8'd1;
  localparam logic [7:0]  TAG_C        = TAG_A + 8'd2;
  localparam logic [7:0]  UNKNOWN_TAG  = 8'hFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
  } field_event_t;

  typedef enum logic [1:0] {
    READY_FULL,
    READY_COIN,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_t;

  logic clk;
  logic rst;

  bhfp_byte_if  bytes ();
  bhfp_event_if events ();

  bitstream_header_field_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes.sink),
    .events (events.source)
  );

  // Header parser model state
  phase_t                 phase;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [31:0]            len_acc;
  logic [31:0]            skip_left;
  logic [2:0]             cur_tag;

  field_event_t expected_events[$];
  logic [7:0]   file_bytes[$];

  int          mismatches = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  ready_mode_t stall_mode = READY_FULL;
  longint      cycles     = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Return the model to the first header length byte
  function automatic void reset_parser_model();
    phase     = PH_HLEN_HI;
    byte_pos  = '0;
    len_acc   = '0;
    skip_left = '0;
    cur_tag   = '0;
  endfunction

  // Advance the model by one byte; return 1 when it yields an event
  function automatic bit parse_header_byte(input logic [7:0] value, input logic is_last,
                                           output field_event_t ev);
    logic [OFFSET_BITS-1:0] here;
    logic [OFFSET_BITS-1:0] after;
    bit                     hit;
    here  = byte_pos;
    after = byte_pos + 1'b1;
    hit   = 1'b0;
    ev    = '0;
    case (phase)
      PH_HLEN_HI: begin
        len_acc = {16'd0, value, 8'd0};
        phase   = PH_HLEN_LO;
      end
      PH_HLEN_LO: begin
        skip_left = (len_acc | {24'd0, value}) + HDR_EXTRA_SKIP;
        phase     = PH_SKIP;
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 1;
        if (skip_left == 0) phase = PH_TAG;
      end
      PH_TAG: begin
        if (value == TAG_E) begin
          len_acc = '0;
          phase   = PH_LEN32_0;
        end else if (value >= TAG_A && value <= TAG_D) begin
          cur_tag = 3'(value - TAG_A);
          len_acc = '0;
          phase   = PH_LEN16_HI;
        end else begin
          ev.kind   = EV_UNKNOWN;
          ev.offset = 32'(here);
          ev.length = '0;
          hit       = 1'b1;
          phase     = PH_IDLE;
        end
      end
      PH_LEN16_HI: begin
        len_acc = {16'd0, value, 8'd0};
        phase   = PH_LEN16_LO;
      end
      PH_LEN16_LO: begin
        len_acc   = len_acc | {24'd0, value};
        ev.kind   = EV_NAME + cur_tag;
        ev.offset = 32'(after);
        ev.length = len_acc;
        hit       = 1'b1;
        skip_left = len_acc;
        phase     = (len_acc == 0) ? PH_TAG : PH_SKIP;
      end
      PH_LEN32_0: begin
        len_acc = {len_acc[23:0], value};
        phase   = PH_LEN32_1;
      end
      PH_LEN32_1: begin
        len_acc = {len_acc[23:0], value};
        phase   = PH_LEN32_2;
      end
      PH_LEN32_2: begin
        len_acc = {len_acc[23:0], value};
        phase   = PH_LEN32_3;
      end
      PH_LEN32_3: begin
        len_acc   = {len_acc[23:0], value};
        ev.kind   = EV_DATA;
        ev.offset = 32'(after);
        ev.length = len_acc;
        hit       = 1'b1;
        phase     = PH_IDLE;
      end
      default: phase = PH_IDLE;
    endcase
    byte_pos = after;
    // End of buffer: report truncation unless an event or the ignore phase covers it
    if (is_last) begin
      if (!hit && phase != PH_IDLE) begin
        ev.kind   = EV_TRUNC;
        ev.offset = 32'(here);
        ev.length = '0;
        hit       = 1'b1;
      end
      reset_parser_model();
    end
    return hit;
  endfunction

  // Send one byte request in bursts with random gaps, then predict its event
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int           gap;
    field_event_t ev;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        bytes.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    bytes.valid     <= 1'b1;
    bytes.data_byte <= value;
    bytes.last_byte <= is_last;
    @(posedge clk);
    while (bytes.ready !== 1'b1) @(posedge clk);
    burst_left = burst_left - 1;
    bytes_sent = bytes_sent + 1;
    if (parse_header_byte(value, is_last, ev)) expected_events.push_back(ev);
  endtask

  // Send the staged buffer, marking its final byte as last
  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  function automatic void add_len16(input int value);
    file_bytes.push_back(8'(value >> 8));
    file_bytes.push_back(8'(value));
  endfunction

  // Receiver stall pattern: hold a random ready mode for a random run, then switch
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = ready_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      READY_FULL:   events.ready <= 1'b1;
      READY_COIN:   events.ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: events.ready <= (cycles[1:0] == 2'd0);
      default:      events.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    mismatches = mismatches + 1;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, what, exp_val,
               act_val);
  endtask

  // Compare each accepted event request with the oldest prediction
  always @(posedge clk) begin
    field_event_t want;
    if (!rst && events.valid === 1'b1 && events.ready === 1'b1) begin
      if (expected_events.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("[%0t] unexpected event: kind %0d offset 0x%0h length 0x%0h", $time,
                   events.event_kind, events.field_offset, events.field_length);
      end else begin
        want = expected_events.pop_front();
        if (events.event_kind !== want.kind)
          note_mismatch("event_kind", 32'(want.kind), 32'(events.event_kind));
        if (events.field_offset !== want.offset)
          note_mismatch("field_offset", want.offset, events.field_offset);
        if (events.field_length !== want.length)
          note_mismatch("field_length", want.length, events.field_length);
      end
    end
  end

  // Name, part, date and data tags after a zero-length leading field, then ignored bytes after data
  task automatic test_tagged_fields();
    file_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF,
                   TAG_A, 8'h00, 8'h00,
                   TAG_B, 8'h00, 8'h01, 8'h5A,
                   TAG_C, 8'h00, 8'h00,
                   TAG_E, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h00, 8'hFF};
    send_file();
  endtask

  // Largest 16-bit length, ended on its own low byte
  task automatic test_max_length();
    file_bytes = '{8'h00, 8'h00, 8'hAA, 8'h55, TAG_D, 8'hFF, 8'hFF};
    send_file();
  endtask

  // Unknown tag, followed by bytes that must be ignored
  task automatic test_unknown_tag();
    file_bytes = '{8'h00, 8'h00, 8'h55, 8'hAA, UNKNOWN_TAG, TAG_A, 8'h00};
    send_file();
  endtask

  // Buffer ending on its first byte and inside the largest leading field
  task automatic test_truncation();
    file_bytes = '{8'h80};
    send_file();
    file_bytes = '{8'hFF, 8'hFF, 8'h00};
    send_file();
  endtask

  // Random buffers: mostly well formed, some cut short, bad-tagged or noise
  task automatic test_random_files();
    int         start;
    int         shape;
    int         hdr_len;
    int         fields;
    int         flen;
    int         cut;
    logic [7:0] bad;
    logic [31:0] data_size;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      shape = $urandom_range(0, 9);
      file_bytes.delete();
      if (shape == 9) begin
        repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        hdr_len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 300) : $urandom_range(0, 6);
        add_len16(hdr_len);
        repeat (hdr_len + 2) file_bytes.push_back(8'($urandom_range(0, 255)));
        fields = $urandom_range(0, 4);
        repeat (fields) begin
          flen = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 200) : $urandom_range(0, 5);
          file_bytes.push_back(TAG_A + 8'($urandom_range(0, 3)));
          add_len16(flen);
          repeat (flen) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (shape == 8) begin
          bad = 8'($urandom_range(0, 255));
          while (bad >= TAG_A && bad <= TAG_E) bad = 8'($urandom_range(0, 255));
          file_bytes.push_back(bad);
        end else begin
          data_size = $urandom;
          file_bytes.push_back(TAG_E);
          file_bytes.push_back(data_size[31:24]);
          file_bytes.push_back(data_size[23:16]);
          file_bytes.push_back(data_size[15:8]);
          file_bytes.push_back(data_size[7:0]);
        end
        repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
        // Cut the buffer short at a random byte
        if (shape == 7) begin
          cut = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
      end
      send_file();
    end
  endtask

  // Main sequence
  initial begin
    rst             = 1'b1;
    bytes.valid     = 1'b0;
    bytes.data_byte = 8'h00;
    bytes.last_byte = 1'b0;
    events.ready    = 1'b0;
    reset_parser_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_tagged_fields();
    test_max_length();
    test_unknown_tag();
    test_truncation();
    test_random_files();

    // Drop the byte request and drain outstanding events
    @(negedge clk);
    bytes.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
